### hdl/dtf_pkg.sv
// Shared constants, tables and types of the decimal text to fixed-point parser.
package dtf_pkg;

  localparam int INT_BITS   = 31;
  localparam int FRAC_BITS  = 32;
  localparam int Q_BITS     = 40;
  localparam int MAG_BITS   = INT_BITS + FRAC_BITS;
  localparam int VALUE_BITS = 64;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int PLACE_DEPTH = 13;
  localparam int PLACE_IDX_W = $clog2(PLACE_DEPTH);
  localparam logic [PLACE_IDX_W-1:0] PLACE_LAST = PLACE_IDX_W'(PLACE_DEPTH - 1);

  localparam logic [Q_BITS-1:0] PLACE_TBL [PLACE_DEPTH] = '{
    40'd109951162777,
    40'd10995116277,
    40'd1099511627,
    40'd109951162,
    40'd10995116,
    40'd1099511,
    40'd109951,
    40'd10995,
    40'd1099,
    40'd109,
    40'd10,
    40'd1,
    40'd0
  };

  typedef struct packed {
    logic [MAG_BITS-1:0] mag;
    logic                negative;
    logic                no_digits;
  } dtf_res_t;

endpackage

### hdl/dtf_if.sv
// Stream interfaces for the parser's byte input and result output.
interface dtf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_last;

  modport source (output valid, output char_byte, output is_last, input ready);
  modport sink (input valid, input char_byte, input is_last, output ready);
endinterface

interface dtf_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        no_digits;

  modport source (output valid, output value, output no_digits, input ready);
  modport sink (input valid, input value, input no_digits, output ready);
endinterface

### hdl/dtf_core.sv
// Parser state, per-byte accumulate and registered magnitude result.
module dtf_core import dtf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  logic [7:0] char_byte_i,
  input  logic     is_last_i,
  output logic     step_ready_o,
  output logic     res_valid_o,
  output dtf_res_t res_o,
  input  logic     res_ready_i
);

  typedef enum logic [1:0] {PH_WS, PH_INT, PH_FRAC, PH_DONE} phase_e;

  localparam logic [INT_BITS+3:0] INT_LIMIT = {4'b0, {INT_BITS{1'b1}}};

  phase_e                 phase_q, phase_d;
  logic                   negative_q, negative_d;
  logic [INT_BITS-1:0]    int_q, int_d;
  logic [Q_BITS-1:0]      frac_q, frac_d;
  logic [PLACE_IDX_W-1:0] place_idx_q, place_idx_d;
  logic                   seen_q, seen_d;
  logic                   sat_q, sat_d;
  logic                   res_valid_q;
  dtf_res_t               res_q, res_d;

  logic                   is_space, is_digit, is_sign;
  logic [3:0]             digit;
  logic [INT_BITS+3:0]    int_ext;
  logic [Q_BITS+4:0]      frac_sum;
  logic                   int_step, frac_step;

  assign is_space = (char_byte_i == CH_SPACE) || (char_byte_i == CH_TAB) ||
                    (char_byte_i == CH_LF) || (char_byte_i == CH_CR) ||
                    (char_byte_i == CH_FF) || (char_byte_i == CH_VT);
  assign is_digit = (char_byte_i >= CH_ZERO) && (char_byte_i <= CH_NINE);
  assign is_sign  = (char_byte_i == CH_PLUS) || (char_byte_i == CH_MINUS);
  assign digit    = 4'(char_byte_i - CH_ZERO);

  assign int_ext  = {1'b0, int_q, 3'b0} + {3'b0, int_q, 1'b0} + {INT_BITS'(0), digit};
  assign frac_sum = {5'b0, frac_q} +
                    ({5'b0, PLACE_TBL[place_idx_q]} * {{(Q_BITS+1){1'b0}}, digit});

  always_comb begin
    int_step  = 1'b0;
    frac_step = 1'b0;
    phase_d   = phase_q;
    negative_d = negative_q;
    unique case (phase_q)
      PH_WS: begin
        if (is_space) begin
          phase_d = PH_WS;
        end else if (is_sign) begin
          negative_d = (char_byte_i == CH_MINUS);
          phase_d    = PH_INT;
        end else if (is_digit) begin
          int_step = 1'b1;
          phase_d  = PH_INT;
        end else if (char_byte_i == CH_POINT) begin
          phase_d = PH_FRAC;
        end else begin
          phase_d = PH_DONE;
        end
      end
      PH_INT: begin
        if (is_digit) begin
          int_step = 1'b1;
        end else if (char_byte_i == CH_POINT) begin
          phase_d = PH_FRAC;
        end else begin
          phase_d = PH_DONE;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          frac_step = 1'b1;
        end else begin
          phase_d = PH_DONE;
        end
      end
      default: phase_d = PH_DONE;
    endcase

    int_d       = int_q;
    sat_d       = sat_q;
    frac_d      = frac_q;
    place_idx_d = place_idx_q;
    seen_d      = seen_q || int_step || frac_step;
    if (int_step && !sat_q) begin
      if (int_ext > INT_LIMIT) begin
        sat_d = 1'b1;
        int_d = {INT_BITS{1'b1}};
      end else begin
        int_d = int_ext[INT_BITS-1:0];
      end
    end
    if (frac_step) begin
      frac_d = (frac_sum[Q_BITS+4:Q_BITS] != 5'd0) ? {Q_BITS{1'b1}} : frac_sum[Q_BITS-1:0];
      if (place_idx_q != PLACE_LAST) begin
        place_idx_d = place_idx_q + 1'b1;
      end
    end

    res_d.negative  = negative_d && seen_d;
    res_d.no_digits = !seen_d;
    if (!seen_d) begin
      res_d.mag = '0;
    end else if (sat_d) begin
      res_d.mag = '1;
    end else begin
      res_d.mag = {int_d, frac_d[Q_BITS-1 -: FRAC_BITS]};
    end
  end

  assign step_ready_o = !is_last_i || !res_valid_q || res_ready_i;
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WS;
      negative_q  <= 1'b0;
      int_q       <= '0;
      frac_q      <= '0;
      place_idx_q <= '0;
      seen_q      <= 1'b0;
      sat_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (step_i && is_last_i) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (step_i) begin
        if (is_last_i) begin
          phase_q     <= PH_WS;
          negative_q  <= 1'b0;
          int_q       <= '0;
          frac_q      <= '0;
          place_idx_q <= '0;
          seen_q      <= 1'b0;
          sat_q       <= 1'b0;
        end else begin
          phase_q     <= phase_d;
          negative_q  <= negative_d;
          int_q       <= int_d;
          frac_q      <= frac_d;
          place_idx_q <= place_idx_d;
          seen_q      <= seen_d;
          sat_q       <= sat_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && is_last_i) begin
      res_q <= res_d;
    end
  end

endmodule

### hdl/decimal_text_to_fixed_parser_top.sv
// Top level of the decimal text to signed Q31.32 fixed-point parser.
//
// in_i carries one character byte per beat, with is_last set on the final
// byte of a string. Leading whitespace, one optional sign, integer digits,
// an optional point and fraction digits are parsed; the first other byte
// ends parsing and later bytes up to is_last are dropped.
// out_o carries one beat per string: value in signed Q31.32, saturated in
// magnitude, and no_digits set when no digit was found (value is then 0).
// Throughput: one byte per cycle unless stalled, set by the state update of
// the parser loop (digit accumulate plus place-value table lookup).
// The result beat is valid once the last byte has passed the input register,
// then the magnitude register, then the output register.
// Reset clears all valid flags and returns the parser to whitespace skip.
// A stalled out_o holds its beat; the magnitude register fills behind it.
// Non-final bytes keep flowing; a final byte waits in the input register,
// and in_i.ready drops, while a result is blocked in the magnitude register.
module decimal_text_to_fixed_parser_top import dtf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  dtf_in_if.sink   in_i,
  dtf_out_if.source out_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       step_ready;
  logic       step;
  logic       res_valid;
  dtf_res_t   res;
  logic       res_take;
  logic       out_valid_q;
  logic [VALUE_BITS-1:0] out_value_q, out_value_d;
  logic       out_nodig_q;
  logic [VALUE_BITS-1:0] mag_ext;

  assign step       = in_valid_q && step_ready;
  assign in_i.ready = !in_valid_q || step_ready;
  assign res_take   = !out_valid_q || out_o.ready;

  dtf_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .char_byte_i  (in_byte_q),
    .is_last_i    (in_last_q),
    .step_ready_o (step_ready),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_take)
  );

  assign mag_ext     = {{(VALUE_BITS-MAG_BITS){1'b0}}, res.mag};
  assign out_value_d = res.negative ? (VALUE_BITS'(0) - mag_ext) : mag_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (res_take) begin
        out_valid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.char_byte;
      in_last_q <= in_i.is_last;
    end
    if (res_take && res_valid) begin
      out_value_q <= out_value_d;
      out_nodig_q <= res.no_digits;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.value     = out_value_q;
  assign out_o.no_digits = out_nodig_q;

endmodule

### sim/tb.sv
// Self-checking stream testbench for the decimal text to Q31.32 fixed-point parser.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtf_pkg::*;

  typedef enum logic [1:0] {SKIP_WS, IN_INT, IN_FRAC, DONE} parse_phase_e;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  no_digits;
  } fixed_result_t;

  typedef logic [7:0] text_t[$];

  localparam logic [Q_BITS-1:0] PLACE_START = Q_BITS'((64'd1 << Q_BITS) / 10);
  localparam logic [63:0] INT_LIMIT = (64'd1 << INT_BITS) - 1;
  localparam logic [63:0] Q_MASK = (64'd1 << Q_BITS) - 1;
  localparam logic [63:0] MAG_MAX = (64'd1 << MAG_BITS) - 1;
  localparam logic [7:0] WS_CHARS [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_FF, CH_VT};
  localparam int SEND_IDLE [4] = '{0, 79, 0, 36};
  localparam int RECV_STALL [4] = '{0, 0, 79, 36};
  localparam int BYTES_PER_PHASE = 375;

  class dtf_scoreboard;
    parse_phase_e ph;
    logic neg;
    logic seen;
    logic sat;
    logic [31:0] int_acc;
    logic [Q_BITS-1:0] frac_acc;
    logic [Q_BITS-1:0] place;
    fixed_result_t pending_numbers[$];
    int bytes_taken;
    int strings_parsed;
    int results_checked;
    int no_digit_count;
    int sat_count;
    int mismatches;

    function new();
      restart();
    endfunction

    function void restart();
      ph = SKIP_WS;
      neg = 1'b0;
      seen = 1'b0;
      sat = 1'b0;
      int_acc = '0;
      frac_acc = '0;
      place = PLACE_START;
    endfunction

    function void add_int_digit(logic [3:0] d);
      logic [63:0] wide;
      seen = 1'b1;
      if (!sat) begin
        wide = 64'(int_acc) * 10 + 64'(d);
        if (wide > INT_LIMIT) begin
          sat = 1'b1;
          int_acc = 32'(INT_LIMIT);
        end else begin
          int_acc = wide[31:0];
        end
      end
    endfunction

    function void add_frac_digit(logic [3:0] d);
      logic [63:0] sum;
      seen = 1'b1;
      sum = 64'(frac_acc) + 64'(d) * 64'(place);
      if (sum > Q_MASK) sum = Q_MASK;
      frac_acc = sum[Q_BITS-1:0];
      place = place / 10;
    endfunction

    function void take_byte(logic [7:0] c, logic last);
      logic is_digit;
      logic [63:0] mag;
      fixed_result_t want;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      bytes_taken++;
      case (ph)
        SKIP_WS: begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            neg = (c == CH_MINUS);
            ph = IN_INT;
          end else if (is_digit) begin
            add_int_digit(4'(c - CH_ZERO));
            ph = IN_INT;
          end else if (c == CH_POINT) begin
            ph = IN_FRAC;
          end else if (!(c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_FF, CH_VT})) begin
            ph = DONE;
          end
        end
        IN_INT: begin
          if (is_digit) add_int_digit(4'(c - CH_ZERO));
          else if (c == CH_POINT) ph = IN_FRAC;
          else ph = DONE;
        end
        IN_FRAC: begin
          if (is_digit) add_frac_digit(4'(c - CH_ZERO));
          else ph = DONE;
        end
        default: ph = DONE;
      endcase
      if (!last) return;
      if (!seen) begin
        want.value = '0;
        want.no_digits = 1'b1;
        no_digit_count++;
      end else begin
        if (sat) begin
          mag = MAG_MAX;
          sat_count++;
        end else begin
          mag = (64'(int_acc) << FRAC_BITS) | (64'(frac_acc) >> (Q_BITS - FRAC_BITS));
        end
        want.value = neg ? -mag : mag;
        want.no_digits = 1'b0;
      end
      pending_numbers.push_back(want);
      strings_parsed++;
      restart();
    endfunction

    function void check_result(logic [VALUE_BITS-1:0] v, logic nd);
      fixed_result_t want;
      if (pending_numbers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with nothing pending: value %h no_digits %b", v, nd);
        return;
      end
      want = pending_numbers.pop_front();
      results_checked++;
      if (v !== want.value || nd !== want.no_digits) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: string %0d: expected value %h no_digits %b, got value %h no_digits %b",
                   results_checked, want.value, want.no_digits, v, nd);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int send_idle_pct;
  int stall_pct;
  int bytes_sent;

  dtf_in_if in_if ();
  dtf_out_if out_if ();
  dtf_scoreboard sb = new();

  decimal_text_to_fixed_parser_top DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.take_byte(in_if.char_byte, in_if.is_last);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.value, out_if.no_digits);
    end
  end

  // Call at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic [7:0] c, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.char_byte <= c;
    in_if.is_last <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_text(input text_t s);
    for (int i = 0; i < s.size(); i++) send_beat(s[i], i == s.size() - 1);
  endtask

  task automatic send_str(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    send_text(t);
  endtask

  task automatic send_random_string();
    text_t s;
    int kind;
    int n;
    logic nines;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    if (kind >= 85) begin
      n = $urandom_range(1, 6);
      repeat (n) s.push_back(8'($urandom_range(0, 255)));
    end else begin
      nines = ($urandom_range(0, 4) == 0);
      n = $urandom_range(0, 3);
      repeat (n) s.push_back(WS_CHARS[$urandom_range(0, 5)]);
      case ($urandom_range(0, 2))
        1: s.push_back(CH_PLUS);
        2: s.push_back(CH_MINUS);
        default: ;
      endcase
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 14) : $urandom_range(0, 10);
      repeat (n) s.push_back(nines ? CH_NINE : CH_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 9) < 7) begin
        s.push_back(CH_POINT);
        n = $urandom_range(0, 14);
        repeat (n) s.push_back(nines ? CH_NINE : CH_ZERO + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 9) < 3) begin
        n = $urandom_range(1, 3);
        repeat (n) s.push_back(8'($urandom_range(0, 255)));
      end
      if (s.size() == 0) s.push_back(WS_CHARS[$urandom_range(0, 5)]);
      if (kind >= 70) begin
        case ($urandom_range(0, 3))
          0: b = CH_PLUS;
          1: b = CH_MINUS;
          2: b = CH_POINT;
          default: b = 8'($urandom_range(0, 255));
        endcase
        s.insert($urandom_range(0, s.size() - 1), b);
      end
    end
    send_text(s);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    in_if.char_byte <= '0;
    in_if.is_last <= 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    bytes_sent = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_str("\t\n\013\f\015 -0");
    send_str("+");
    send_str(".");
    send_str("\377");
    send_str("-2147483648");
    send_str("1.5.9");
    send_str("--1");
    send_str("7ex9");
    send_str("-.9999999999999");

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = SEND_IDLE[p];
      stall_pct = RECV_STALL[p];
      n_loop: while (bytes_sent < (p + 1) * BYTES_PER_PHASE + 48) send_random_string();
    end
    in_if.valid <= 1'b0;

    while (sb.pending_numbers.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Summary: %0d strings in %0d bytes, %0d without digits, %0d saturated",
             sb.strings_parsed, sb.bytes_taken, sb.no_digit_count, sb.sat_count);
    $display("Summary: %0d results checked, %0d mismatches, %0d still pending",
             sb.results_checked, sb.mismatches, sb.pending_numbers.size());
    if (sb.mismatches == 0 && sb.pending_numbers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results pending", sb.pending_numbers.size());
    $display("TEST FAILED");
    $finish;
  end
endmodule
